[hw/rtl/okl_pkg.sv]
// Shared constants and operation/status codes for the ordered keyed list table.
package okl_pkg;

	localparam int DEPTH        = 64;
	localparam int ID_BITS      = 16;
	localparam int PAYLOAD_BITS = 32;

	localparam int OP_W = 2;
	localparam int ST_W = 2;

	localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

	localparam logic [ST_W-1:0] ST_DONE = 2'd0;
	localparam logic [ST_W-1:0] ST_MISS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

endpackage

[hw/rtl/okl_req_if.sv]
// Operation request channel: valid/ready with operation, key and payload.
interface okl_req_if #(
	parameter int ID_BITS      = okl_pkg::ID_BITS,
	parameter int PAYLOAD_BITS = okl_pkg::PAYLOAD_BITS
);

	typedef struct packed {
		logic [okl_pkg::OP_W-1:0] operation;
		logic [ID_BITS-1:0]       key_id;
		logic [PAYLOAD_BITS-1:0]  entry_payload;
	} req_t;

	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

[hw/rtl/okl_rsp_if.sv]
// Result channel: valid/ready with status, position, payload and list count.
interface okl_rsp_if #(
	parameter int DEPTH        = okl_pkg::DEPTH,
	parameter int PAYLOAD_BITS = okl_pkg::PAYLOAD_BITS
);

	typedef struct packed {
		logic [okl_pkg::ST_W-1:0]     status;
		logic [$clog2(DEPTH)-1:0]     match_position;
		logic [PAYLOAD_BITS-1:0]      match_payload;
		logic [$clog2(DEPTH+1)-1:0]   entry_count;
		logic                         list_empty;
	} rsp_t;

	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

[hw/rtl/okl_ram.sv]
// Entry store: one write port, one read port with registered read data.
module okl_ram #(
	parameter int DEPTH = okl_pkg::DEPTH,
	parameter int WIDTH = okl_pkg::ID_BITS + okl_pkg::PAYLOAD_BITS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/ordered_keyed_list_table_unit.sv]
// Top level: insertion-ordered keyed list with append, remove and search.
//
//   channel | dir | carries
//   --------+-----+-------------------------------------------------------------
//   req     | in  | operation, key_id, entry_payload
//   rsp     | out | status, match_position, match_payload, entry_count, list_empty
//
// Append and the unused code go from transfer straight to the result state. Search
// and remove walk the store one entry per cycle through its single read port,
// and remove then moves each later entry up one place, again one per cycle.
// Reset clears the entry count, state and output valid; the store itself is not swept.
// A finished result waits in the output register; the next request is taken
// meanwhile and its result waits in turn until the output register frees.
module ordered_keyed_list_table_unit #(
	parameter int DEPTH        = okl_pkg::DEPTH,
	parameter int ID_BITS      = okl_pkg::ID_BITS,
	parameter int PAYLOAD_BITS = okl_pkg::PAYLOAD_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	okl_req_if.sink     req,
	okl_rsp_if.source   rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = ID_BITS + PAYLOAD_BITS;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_SHIFT = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] cmp_idx_q, cmp_idx_d;
	logic inflight_q, inflight_d;
	logic [okl_pkg::OP_W-1:0] op_q, op_d;
	logic [ID_BITS-1:0] key_q, key_d;
	logic [okl_pkg::ST_W-1:0] res_status_q, res_status_d;
	logic [AW-1:0] res_pos_q, res_pos_d;
	logic [PAYLOAD_BITS-1:0] res_pay_q, res_pay_d;

	logic out_valid_q;
	logic [okl_pkg::ST_W-1:0] out_status_q;
	logic [AW-1:0] out_pos_q;
	logic [PAYLOAD_BITS-1:0] out_pay_q;
	logic [CW-1:0] out_count_q;
	logic out_empty_q;
	logic load_out;

	logic ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [MW-1:0] ram_wdata, ram_rdata;
	logic [ID_BITS-1:0] rd_id;
	logic [PAYLOAD_BITS-1:0] rd_pay;

	logic accept, issue_ok, hit, last_cmp;
	logic [CW-1:0] next_idx;

	okl_ram #(
		.DEPTH(DEPTH),
		.WIDTH(MW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_id  = ram_rdata[MW-1:PAYLOAD_BITS];
	assign rd_pay = ram_rdata[PAYLOAD_BITS-1:0];

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	// the one comparator against the key, plus the walk bound
	assign issue_ok = (ptr_q < count_q);
	assign hit      = inflight_q && (rd_id == key_q);
	assign next_idx = CW'(cmp_idx_q) + CW'(1);
	assign last_cmp = (next_idx == count_q);

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		ptr_d        = ptr_q;
		cmp_idx_d    = cmp_idx_q;
		inflight_d   = inflight_q;
		op_d         = op_q;
		key_d        = key_q;
		res_status_d = res_status_q;
		res_pos_d    = res_pos_q;
		res_pay_d    = res_pay_q;
		ram_we       = 1'b0;
		ram_waddr    = count_q[AW-1:0];
		ram_wdata    = {req.payload.key_id, req.payload.entry_payload};
		ram_re       = 1'b0;
		ram_raddr    = ptr_q[AW-1:0];
		load_out     = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_d         = req.payload.operation;
					key_d        = req.payload.key_id;
					res_status_d = okl_pkg::ST_DONE;
					res_pos_d    = '0;
					res_pay_d    = '0;
					ptr_d        = '0;
					inflight_d   = 1'b0;
					state_d      = S_OUT;
					case (req.payload.operation)
						okl_pkg::OP_APPEND: begin
							if (count_q == CW'(DEPTH)) begin
								res_status_d = okl_pkg::ST_FULL;
							end else begin
								ram_we    = 1'b1;
								res_pos_d = count_q[AW-1:0];
								count_d   = count_q + CW'(1);
							end
						end
						okl_pkg::OP_REMOVE, okl_pkg::OP_SEARCH: begin
							if (count_q == '0) begin
								res_status_d = okl_pkg::ST_MISS;
							end else begin
								state_d = S_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				if (hit) begin
					res_pos_d = cmp_idx_q;
					if (op_q == okl_pkg::OP_SEARCH) begin
						res_pay_d = rd_pay;
						state_d   = S_OUT;
					end else if (next_idx < count_q) begin
						ptr_d      = next_idx;
						inflight_d = 1'b0;
						state_d    = S_SHIFT;
					end else begin
						count_d = count_q - CW'(1);
						state_d = S_OUT;
					end
				end else if (inflight_q && last_cmp) begin
					res_status_d = okl_pkg::ST_MISS;
					state_d      = S_OUT;
				end else begin
					ram_re     = issue_ok;
					inflight_d = issue_ok;
					cmp_idx_d  = ptr_q[AW-1:0];
					if (issue_ok) begin
						ptr_d = ptr_q + CW'(1);
					end
				end
			end
			S_SHIFT: begin
				// read runs one entry ahead of the write that moves it up
				ram_re     = issue_ok;
				inflight_d = issue_ok;
				cmp_idx_d  = ptr_q[AW-1:0];
				if (issue_ok) begin
					ptr_d = ptr_q + CW'(1);
				end
				if (inflight_q) begin
					ram_we    = 1'b1;
					ram_waddr = cmp_idx_q - AW'(1);
					ram_wdata = ram_rdata;
					if (last_cmp) begin
						count_d    = count_q - CW'(1);
						inflight_d = 1'b0;
						state_d    = S_OUT;
					end
				end
			end
			S_OUT: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			inflight_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			inflight_q <= inflight_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q        <= ptr_d;
		cmp_idx_q    <= cmp_idx_d;
		op_q         <= op_d;
		key_q        <= key_d;
		res_status_q <= res_status_d;
		res_pos_q    <= res_pos_d;
		res_pay_q    <= res_pay_d;
		if (load_out) begin
			out_status_q <= res_status_q;
			out_pos_q    <= res_pos_q;
			out_pay_q    <= res_pay_q;
			out_count_q  <= count_q;
			out_empty_q  <= (count_q == '0);
		end
	end

	assign rsp.valid                  = out_valid_q;
	assign rsp.payload.status         = out_status_q;
	assign rsp.payload.match_position = out_pos_q;
	assign rsp.payload.match_payload  = out_pay_q;
	assign rsp.payload.entry_count    = out_count_q;
	assign rsp.payload.list_empty     = out_empty_q;

endmodule
